// ----- rtl/core/sed_pkg.sv -----
// ----------------------------------------------------------------------------
// sed_pkg
// Shared types, constants and register codes of the sound event detector.
// ----------------------------------------------------------------------------
package sed_pkg;

  // default sample width of the microphone channels
  localparam int unsigned SAMPLE_BITS_DEF = 12;

  // configuration port geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // register reset values
  localparam logic [15:0] RST_WINDOW_SAMPLES     = 16'd8000;
  localparam logic [11:0] RST_LEVEL_THRESHOLD    = 12'd3500;
  localparam logic [7:0]  RST_COOLDOWN_WINDOWS   = 8'd6;
  localparam logic [7:0]  RST_PERIODIC_WINDOWS   = 8'd20;
  localparam logic [15:0] RST_WINDOW_TIME_MS     = 16'd820;
  localparam logic [15:0] RST_FIRST_EVENT_NUMBER = 16'd1000;

  // intensity scaling: level * 100 / 4095, where 4095 = 2^12 - 1
  localparam int unsigned PCT_SCALE  = 100;
  localparam int unsigned DIV_SHIFT  = 12;
  localparam int unsigned FULL_SCALE = (1 << DIV_SHIFT) - 1;
  localparam int unsigned PCT_W      = 7;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_SAMPLES     = 3'd0,
    CFG_LEVEL_THRESHOLD    = 3'd1,
    CFG_COOLDOWN_WINDOWS   = 3'd2,
    CFG_PERIODIC_WINDOWS   = 3'd3,
    CFG_WINDOW_TIME_MS     = 3'd4,
    CFG_FIRST_EVENT_NUMBER = 3'd5
  } cfg_idx_e;

  // loudest channel codes
  typedef enum logic [1:0] {
    SIDE_LEFT  = 2'd0,
    SIDE_FRONT = 2'd1,
    SIDE_RIGHT = 2'd2
  } side_e;

  // configuration register set
  typedef struct packed {
    logic [15:0] window_samples;
    logic [11:0] level_threshold;
    logic [7:0]  cooldown_windows;
    logic [7:0]  periodic_windows;
    logic [15:0] window_time_ms;
    logic [15:0] first_event_number;
  } cfg_t;

endpackage

// ----- rtl/core/sed_if.sv -----
// ----------------------------------------------------------------------------
// sed_if
// Valid/ready channels of the sound event detector: sample triples in,
// window results out.
// ----------------------------------------------------------------------------
interface sed_in_if #(
  parameter int unsigned SAMPLE_BITS = sed_pkg::SAMPLE_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_left;
  logic [SAMPLE_BITS-1:0] sample_front;
  logic [SAMPLE_BITS-1:0] sample_right;

  modport source (
    output valid, sample_left, sample_front, sample_right,
    input  ready
  );
  modport sink (
    input  valid, sample_left, sample_front, sample_right,
    output ready
  );
endinterface

interface sed_out_if #(
  parameter int unsigned SAMPLE_BITS = sed_pkg::SAMPLE_BITS_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic [SAMPLE_BITS-1:0]         peak_level;
  logic [1:0]                     loudest_side;
  logic                           event_fired;
  logic                           high_priority;
  logic [sed_pkg::PCT_W-1:0]      intensity_percent;
  logic [31:0]                    event_number;
  logic [31:0]                    elapsed_ms;
  logic [7:0]                     cooldown_left;
  logic [7:0]                     windows_since_event;

  modport source (
    output valid, peak_level, loudest_side, event_fired, high_priority,
           intensity_percent, event_number, elapsed_ms, cooldown_left,
           windows_since_event,
    input  ready
  );
  modport sink (
    input  valid, peak_level, loudest_side, event_fired, high_priority,
           intensity_percent, event_number, elapsed_ms, cooldown_left,
           windows_since_event,
    output ready
  );
endinterface

// ----- rtl/core/sed_regs.sv -----
// ----------------------------------------------------------------------------
// sed_regs
// Configuration register file, written through a plain index/data port.
// ----------------------------------------------------------------------------
module sed_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sed_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sed_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output sed_pkg::cfg_t                     cfg_o
);

  sed_pkg::cfg_t cfg_q, cfg_d;

  // register write decode, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (sed_pkg::cfg_idx_e'(cfg_idx_i))
        sed_pkg::CFG_WINDOW_SAMPLES:     cfg_d.window_samples     = cfg_data_i[15:0];
        sed_pkg::CFG_LEVEL_THRESHOLD:    cfg_d.level_threshold    = cfg_data_i[11:0];
        sed_pkg::CFG_COOLDOWN_WINDOWS:   cfg_d.cooldown_windows   = cfg_data_i[7:0];
        sed_pkg::CFG_PERIODIC_WINDOWS:   cfg_d.periodic_windows   = cfg_data_i[7:0];
        sed_pkg::CFG_WINDOW_TIME_MS:     cfg_d.window_time_ms     = cfg_data_i[15:0];
        sed_pkg::CFG_FIRST_EVENT_NUMBER: cfg_d.first_event_number = cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_samples     <= sed_pkg::RST_WINDOW_SAMPLES;
      cfg_q.level_threshold    <= sed_pkg::RST_LEVEL_THRESHOLD;
      cfg_q.cooldown_windows   <= sed_pkg::RST_COOLDOWN_WINDOWS;
      cfg_q.periodic_windows   <= sed_pkg::RST_PERIODIC_WINDOWS;
      cfg_q.window_time_ms     <= sed_pkg::RST_WINDOW_TIME_MS;
      cfg_q.first_event_number <= sed_pkg::RST_FIRST_EVENT_NUMBER;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/sed_track.sv -----
// ----------------------------------------------------------------------------
// sed_track
// Per-channel running min/max over a window; at window close the three
// peak-to-peak spans go to a window register.
// ----------------------------------------------------------------------------
module sed_track #(
  parameter int unsigned SAMPLE_BITS = sed_pkg::SAMPLE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  sed_in_if.sink                      in_ch,
  input  logic [15:0]                 window_samples_i,
  input  logic                        win_ready_i,
  output logic                        win_valid_o,
  output logic [2:0][SAMPLE_BITS-1:0] span_o
);

  localparam logic [SAMPLE_BITS-1:0] SampleMax = {SAMPLE_BITS{1'b1}};

  logic [2:0][SAMPLE_BITS-1:0] smp;
  logic [2:0][SAMPLE_BITS-1:0] max_q, max_d, min_q, min_d;
  logic [2:0][SAMPLE_BITS-1:0] mx_n, mn_n, sp_n;
  logic [2:0][SAMPLE_BITS-1:0] span_q, span_d;
  logic [15:0]                 cnt_q, cnt_d, cnt_inc, limit;
  logic                        win_valid_q, win_valid_d;
  logic                        take, close;

  // lanes: 0 left, 1 front, 2 right
  assign smp[0] = in_ch.sample_left;
  assign smp[1] = in_ch.sample_front;
  assign smp[2] = in_ch.sample_right;

  assign in_ch.ready = !win_valid_q || win_ready_i;
  assign take        = in_ch.valid && in_ch.ready;

  // compare-update per lane and span of the updated extremes
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      mx_n[l] = (smp[l] > max_q[l]) ? smp[l] : max_q[l];
      mn_n[l] = (smp[l] < min_q[l]) ? smp[l] : min_q[l];
      sp_n[l] = (mx_n[l] >= mn_n[l]) ? (mx_n[l] - mn_n[l]) : '0;
    end
  end

  // saturating sample count, a zero window length acts as one
  assign cnt_inc = (cnt_q != 16'hFFFF) ? (cnt_q + 16'd1) : cnt_q;
  assign limit   = (window_samples_i == '0) ? 16'd1 : window_samples_i;
  assign close   = (cnt_inc >= limit);

  // next state
  always_comb begin
    max_d       = max_q;
    min_d       = min_q;
    cnt_d       = cnt_q;
    span_d      = span_q;
    win_valid_d = win_ready_i ? 1'b0 : win_valid_q;
    if (take) begin
      if (close) begin
        max_d       = '0;
        min_d       = {3{SampleMax}};
        cnt_d       = '0;
        span_d      = sp_n;
        win_valid_d = 1'b1;
      end else begin
        max_d = mx_n;
        min_d = mn_n;
        cnt_d = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= '0;
      min_q       <= {3{SampleMax}};
      cnt_q       <= '0;
      win_valid_q <= 1'b0;
    end else begin
      max_q       <= max_d;
      min_q       <= min_d;
      cnt_q       <= cnt_d;
      win_valid_q <= win_valid_d;
    end
  end

  // span payload
  always_ff @(posedge clk_i) begin
    span_q <= span_d;
  end

  assign win_valid_o = win_valid_q;
  assign span_o      = span_q;

  // a closing sample restarts the window and posts its spans
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && close) |=> (win_valid_q && cnt_q == '0))
    else $error("window close did not restart count or post spans");

  // a posted window waits until the decision stage takes it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (win_valid_q && !win_ready_i) |=> (win_valid_q && $stable(span_q)))
    else $error("pending window lost while decision stage stalled");

  // no sample is taken while a pending window cannot move
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (win_valid_q && !win_ready_i) |=> $stable(cnt_q))
    else $error("window state changed while stalled");

endmodule

// ----- rtl/core/sed_decide.sv -----
// ----------------------------------------------------------------------------
// sed_decide
// Picks the loudest channel of a closed window, runs cooldown, window count,
// elapsed time and event numbering, and holds the result register.
// ----------------------------------------------------------------------------
module sed_decide #(
  parameter int unsigned SAMPLE_BITS = sed_pkg::SAMPLE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sed_pkg::cfg_t               cfg_i,
  input  logic                        win_valid_i,
  output logic                        win_ready_o,
  input  logic [2:0][SAMPLE_BITS-1:0] span_i,
  sed_out_if.source                   out_ch
);

  localparam int unsigned CmpW = (SAMPLE_BITS > 12) ? SAMPLE_BITS : 12;
  localparam int unsigned PW   = SAMPLE_BITS + sed_pkg::PCT_W;
  localparam int unsigned QW   = PW - sed_pkg::DIV_SHIFT;
  localparam int unsigned RW   = sed_pkg::DIV_SHIFT + 1;

  logic                   take;
  logic [SAMPLE_BITS-1:0] peak;
  sed_pkg::side_e         side;
  logic [7:0]             cd_dec, wc_inc;
  logic [31:0]            time_n, evnum;
  logic                   high, periodic, fire;
  logic [PW-1:0]          prod;
  logic [QW-1:0]          q0, quo;
  logic [RW-1:0]          rem;
  logic [sed_pkg::PCT_W-1:0] pct;

  // decision state
  logic [7:0]  cd_q, cd_d, wc_q, wc_d;
  logic [31:0] time_q, time_d, next_num_q, next_num_d;
  logic        any_q, any_d;

  // result register
  logic                      res_valid_q, res_valid_d;
  logic [SAMPLE_BITS-1:0]    res_peak_q;
  sed_pkg::side_e            res_side_q;
  logic                      res_fire_q, res_high_q;
  logic [sed_pkg::PCT_W-1:0] res_pct_q;
  logic [31:0]               res_num_q, res_time_q;
  logic [7:0]                res_cd_q, res_wc_q;

  assign win_ready_o = !res_valid_q || out_ch.ready;
  assign take        = win_valid_i && win_ready_o;

  // loudest channel, ties keep the earlier one
  always_comb begin
    peak = span_i[0];
    side = sed_pkg::SIDE_LEFT;
    if (span_i[1] > peak) begin
      peak = span_i[1];
      side = sed_pkg::SIDE_FRONT;
    end
    if (span_i[2] > peak) begin
      peak = span_i[2];
      side = sed_pkg::SIDE_RIGHT;
    end
  end

  // intensity: x / (2^12 - 1) = (x >> 12) plus one correction step
  assign prod = PW'(peak) * PW'(sed_pkg::PCT_SCALE);
  assign q0   = prod[PW-1:sed_pkg::DIV_SHIFT];
  assign rem  = RW'(prod[sed_pkg::DIV_SHIFT-1:0]) + RW'(q0);
  assign quo  = q0 + QW'(rem >= RW'(sed_pkg::FULL_SCALE));
  assign pct  = sed_pkg::PCT_W'(quo);

  // counters and trigger tests
  assign cd_dec   = (cd_q != '0) ? (cd_q - 8'd1) : cd_q;
  assign wc_inc   = (wc_q != 8'hFF) ? (wc_q + 8'd1) : wc_q;
  assign time_n   = time_q + 32'(cfg_i.window_time_ms);
  assign high     = (CmpW'(peak) > CmpW'(cfg_i.level_threshold)) && (cd_dec == '0);
  assign periodic = (wc_inc >= cfg_i.periodic_windows);
  assign fire     = high || periodic;
  assign evnum    = !fire ? '0 :
                    (any_q ? next_num_q : 32'(cfg_i.first_event_number));

  // state update on a taken window
  always_comb begin
    cd_d        = cd_q;
    wc_d        = wc_q;
    time_d      = time_q;
    next_num_d  = next_num_q;
    any_d       = any_q;
    res_valid_d = out_ch.ready ? 1'b0 : res_valid_q;
    if (take) begin
      res_valid_d = 1'b1;
      time_d      = time_n;
      cd_d        = cd_dec;
      wc_d        = wc_inc;
      if (fire) begin
        next_num_d = evnum + 32'd1;
        any_d      = 1'b1;
        wc_d       = '0;
        if (high) begin
          cd_d = cfg_i.cooldown_windows;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cd_q        <= '0;
      wc_q        <= '0;
      time_q      <= '0;
      next_num_q  <= 32'(sed_pkg::RST_FIRST_EVENT_NUMBER);
      any_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      cd_q        <= cd_d;
      wc_q        <= wc_d;
      time_q      <= time_d;
      next_num_q  <= next_num_d;
      any_q       <= any_d;
      res_valid_q <= res_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      res_peak_q <= peak;
      res_side_q <= side;
      res_fire_q <= fire;
      res_high_q <= high;
      res_pct_q  <= pct;
      res_num_q  <= evnum;
      res_time_q <= time_n;
      res_cd_q   <= cd_dec;
      res_wc_q   <= wc_inc;
    end
  end

  assign out_ch.valid               = res_valid_q;
  assign out_ch.peak_level          = res_peak_q;
  assign out_ch.loudest_side        = res_side_q;
  assign out_ch.event_fired         = res_fire_q;
  assign out_ch.high_priority       = res_high_q;
  assign out_ch.intensity_percent   = res_pct_q;
  assign out_ch.event_number        = res_num_q;
  assign out_ch.elapsed_ms          = res_time_q;
  assign out_ch.cooldown_left       = res_cd_q;
  assign out_ch.windows_since_event = res_wc_q;

  // every taken window shows up in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> (res_valid_q && res_time_q == time_q))
    else $error("result missing or time stamp out of step");

  // a high event reloads the cooldown
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && high) |=> (cd_q == $past(cfg_i.cooldown_windows)))
    else $error("cooldown not reloaded after high event");

  // any event restarts the window count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && fire) |=> (wc_q == '0 && any_q))
    else $error("window count not cleared after event");

endmodule

// ----- rtl/core/three_channel_sound_event_detector_top.sv -----
// ----------------------------------------------------------------------------
// three_channel_sound_event_detector_top
// Three-channel sound level tracker with threshold and periodic events.
//
// in_ch_i carries one word per sample triple (left, front, right). Each
// channel's min/max is tracked over window_samples words; the word that
// closes a window yields one word on out_ch_o with the peak level, loudest
// side, intensity percent and event fields. Other words yield nothing.
// A closing word passes through the window register, then the result
// register, before it appears on out_ch_o.
// Throughput: one input word per cycle while the window register can drain,
// set by the single min/max compare-update per channel and the decision stage.
// Reset clears the window, cooldown, window count, elapsed time and event
// numbering, and loads the register defaults. Registers are written through
// cfg_we_i/cfg_idx_i/cfg_data_i, by the user only while the block is idle;
// the block itself does not enforce this. When the receiver stalls, the
// result word holds; one more closed window can wait in the window register,
// and input words keep being taken until that register is also full.
// ----------------------------------------------------------------------------
module three_channel_sound_event_detector_top #(
  parameter int unsigned SAMPLE_BITS = sed_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  sed_in_if.sink                         in_ch_i,
  sed_out_if.source                      out_ch_o,
  input  logic                           cfg_we_i,
  input  logic [sed_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sed_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  sed_pkg::cfg_t               cfg;
  logic                        win_valid, win_ready;
  logic [2:0][SAMPLE_BITS-1:0] span;

  // configuration registers
  sed_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // window min/max tracking
  sed_track #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_track (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_ch            (in_ch_i),
    .window_samples_i (cfg.window_samples),
    .win_ready_i      (win_ready),
    .win_valid_o      (win_valid),
    .span_o           (span)
  );

  // loudest channel and event decision
  sed_decide #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_decide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .win_valid_i (win_valid),
    .win_ready_o (win_ready),
    .span_i      (span),
    .out_ch      (out_ch_o)
  );

endmodule
